// ===== rtl/core/atab_pkg.sv =====
// Shared types and constants for the ATA task-file address builder.
// No dependencies; every other file in rtl/core refers to this package.
package atab_pkg;

   localparam int unsigned BLOCK_FIELD_W = 28;
   localparam int unsigned CSR_INDEX_W   = 3;
   localparam int unsigned CSR_DATA_W    = 29;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_LBA_MODE          = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAD_COUNT        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECTORS_PER_TRACK = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY_BLOCKS   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLAVE_SELECT      = 3'd4;

   // Task-file register codes.
   localparam logic [7:0] DH_BASE   = 8'hA0;
   localparam logic [7:0] DH_SLAVE  = 8'h10;
   localparam logic [7:0] DH_LBA    = 8'h40;
   localparam logic [7:0] CMD_READ  = 8'h20;
   localparam logic [7:0] CMD_WRITE = 8'h30;

   localparam logic [4:0] MAX_HEADS = 5'd16;

   // Widths of the two divider chains.
   localparam int unsigned CYL_REM_W  = 10;  // heads * sectors_per_track <= 1008
   localparam int unsigned HEAD_REM_W = 6;   // sectors_per_track <= 63
   localparam int unsigned HEAD_Q_W   = 4;   // head index < 16

   typedef struct packed {
      logic [BLOCK_FIELD_W-1:0] block_number;
      logic                     write_request;
   } atab_req_type;

   typedef struct packed {
      logic       range_error;
      logic [7:0] sector_byte;
      logic [7:0] cylinder_low_byte;
      logic [7:0] cylinder_high_byte;
      logic [7:0] drive_head_byte;
      logic [7:0] command_byte;
   } atab_rsp_type;

   // Side information that travels with a request down the cell chain.
   typedef struct packed {
      logic                     err;
      logic                     lba;
      logic                     wr;
      logic [BLOCK_FIELD_W-1:0] block;
      logic [15:0]              cyl;
   } atab_tag_type;

endpackage

// ===== rtl/core/atab_div_cell.sv =====
// One restoring-division cell: produces one quotient bit and registers it.
// Depends on atab_pkg for the side-information type.
module atab_div_cell #(
   parameter int unsigned REM_W = 10,
   parameter int unsigned NUM_W = 28
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   input  logic [REM_W-1:0]      up_rem,
   input  logic [NUM_W-1:0]      up_num,
   input  atab_pkg::atab_tag_type up_tag,
   input  logic [REM_W-1:0]      divisor,
   output logic                  up_hold,
   output logic                  dn_valid,
   output logic [REM_W-1:0]      dn_rem,
   output logic [NUM_W-1:0]      dn_num,
   output atab_pkg::atab_tag_type dn_tag,
   input  logic                  dn_hold
);

   logic                   valid_ff;
   logic [REM_W-1:0]       rem_ff;
   logic [REM_W-1:0]       rem_in;
   logic [NUM_W-1:0]       num_ff;
   logic [NUM_W-1:0]       num_in;
   atab_pkg::atab_tag_type tag_ff;
   logic [REM_W:0]         trial;
   logic [REM_W:0]         div_ext;
   logic [REM_W:0]         diff;
   logic                   fits;

   // The dividend moves out at the top of num while quotient bits enter at the bottom.
   always_comb begin
      trial   = {up_rem, up_num[NUM_W-1]};
      div_ext = {1'b0, divisor};
      diff    = trial - div_ext;
      fits    = (trial >= div_ext);
      rem_in  = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
      num_in  = {up_num[NUM_W-2:0], fits};
   end

   assign up_hold = valid_ff & dn_hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!up_hold) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!up_hold) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
         tag_ff <= up_tag;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_num   = num_ff;
   assign dn_tag   = tag_ff;

endmodule

// ===== rtl/core/atab_div_chain.sv =====
// A row of division cells, one per quotient bit, with a per-cell hold chain.
// Depends on atab_pkg and atab_div_cell.
module atab_div_chain #(
   parameter int unsigned REM_W = 10,
   parameter int unsigned NUM_W = 28
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   input  logic [REM_W-1:0]      up_rem,
   input  logic [NUM_W-1:0]      up_num,
   input  atab_pkg::atab_tag_type up_tag,
   input  logic [REM_W-1:0]      divisor,
   output logic                  up_hold,
   output logic                  dn_valid,
   output logic [REM_W-1:0]      dn_rem,
   output logic [NUM_W-1:0]      dn_num,
   output atab_pkg::atab_tag_type dn_tag,
   input  logic                  dn_hold
);

   logic                   valid_s [0:NUM_W];
   logic [REM_W-1:0]       rem_s   [0:NUM_W];
   logic [NUM_W-1:0]       num_s   [0:NUM_W];
   atab_pkg::atab_tag_type tag_s   [0:NUM_W];
   logic                   hold_s  [0:NUM_W];

   assign valid_s[0]     = up_valid;
   assign rem_s[0]       = up_rem;
   assign num_s[0]       = up_num;
   assign tag_s[0]       = up_tag;
   assign hold_s[NUM_W]  = dn_hold;

   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      atab_div_cell #(
         .REM_W (REM_W),
         .NUM_W (NUM_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (valid_s[i]),
         .up_rem   (rem_s[i]),
         .up_num   (num_s[i]),
         .up_tag   (tag_s[i]),
         .divisor  (divisor),
         .up_hold  (hold_s[i]),
         .dn_valid (valid_s[i+1]),
         .dn_rem   (rem_s[i+1]),
         .dn_num   (num_s[i+1]),
         .dn_tag   (tag_s[i+1]),
         .dn_hold  (hold_s[i+1])
      );
   end

   assign up_hold  = hold_s[0];
   assign dn_valid = valid_s[NUM_W];
   assign dn_rem   = rem_s[NUM_W];
   assign dn_num   = num_s[NUM_W];
   assign dn_tag   = tag_s[NUM_W];

endmodule

// ===== rtl/core/ata_task_file_address_builder.sv =====
// A request passes through one division cell per quotient bit plus an output register.
// Throughput: one request per cycle while req_stall is low; a stalled result holds
// only the cells behind it, and empty cells ahead of the stall keep filling.
// Reset clears all valid bits and loads the configuration defaults.
// Depends on atab_pkg, atab_div_chain and atab_div_cell.
module ata_task_file_address_builder #(
   parameter int unsigned BLOCK_BITS = 28
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  atab_pkg::atab_req_type                req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output atab_pkg::atab_rsp_type                rsp_payload,
   input  logic                                  csr_write_enable,
   input  logic [atab_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [atab_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   localparam logic [28:0] BLOCK_LIMIT = 29'(29'd1 << BLOCK_BITS);
   localparam logic [27:0] BLOCK_MASK  = 28'(BLOCK_LIMIT - 29'd1);

   localparam int unsigned CRW = atab_pkg::CYL_REM_W;
   localparam int unsigned HRW = atab_pkg::HEAD_REM_W;
   localparam int unsigned HQW = atab_pkg::HEAD_Q_W;

   // Configuration registers.
   logic        lba_mode_ff;
   logic [4:0]  head_count_ff;
   logic [5:0]  sectors_ff;
   logic [28:0] capacity_ff;
   logic        slave_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lba_mode_ff   <= 1'b0;
         head_count_ff <= 5'd16;
         sectors_ff    <= 6'd63;
         capacity_ff   <= 29'd0;
         slave_ff      <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            atab_pkg::CSR_LBA_MODE:          lba_mode_ff   <= csr_write_data[0];
            atab_pkg::CSR_HEAD_COUNT:        head_count_ff <= csr_write_data[4:0];
            atab_pkg::CSR_SECTORS_PER_TRACK: sectors_ff    <= csr_write_data[5:0];
            atab_pkg::CSR_CAPACITY_BLOCKS:   capacity_ff   <= csr_write_data[28:0];
            atab_pkg::CSR_SLAVE_SELECT:      slave_ff      <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Derived geometry; user keeps it stable while requests are in flight; unchecked.
   logic [4:0]   heads;
   logic [10:0]  per_cyl_full;
   logic [CRW-1:0] per_cyl;

   always_comb begin
      heads        = (head_count_ff > atab_pkg::MAX_HEADS) ? atab_pkg::MAX_HEADS
                                                            : head_count_ff;
      per_cyl_full = 11'(heads) * 11'(sectors_ff);
      per_cyl      = per_cyl_full[CRW-1:0];
   end

   // Entry into the cylinder chain.
   logic [27:0]            blk;
   atab_pkg::atab_tag_type entry_tag;
   logic                   c1_hold;

   always_comb begin
      blk                = req_payload.block_number & BLOCK_MASK;
      entry_tag.err      = ({1'b0, blk} >= capacity_ff) ||
                           (!lba_mode_ff && (heads == 5'd0 || sectors_ff == 6'd0));
      entry_tag.lba      = lba_mode_ff;
      entry_tag.wr       = req_payload.write_request;
      entry_tag.block    = blk;
      entry_tag.cyl      = 16'd0;
   end

   assign req_stall = c1_hold;

   logic                   c1_valid;
   logic [CRW-1:0]         c1_rem;
   logic [BLOCK_BITS-1:0]  c1_num;
   atab_pkg::atab_tag_type c1_tag;
   logic                   c2_hold;

   atab_div_chain #(
      .REM_W (CRW),
      .NUM_W (BLOCK_BITS)
   ) u_cyl_chain (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_rem   ({CRW{1'b0}}),
      .up_num   (blk[BLOCK_BITS-1:0]),
      .up_tag   (entry_tag),
      .divisor  (per_cyl),
      .up_hold  (c1_hold),
      .dn_valid (c1_valid),
      .dn_rem   (c1_rem),
      .dn_num   (c1_num),
      .dn_tag   (c1_tag),
      .dn_hold  (c2_hold)
   );

   // The remainder is below 16 * sectors_per_track, so its upper bits are already
   // smaller than the divisor and only four quotient bits remain.
   logic [27:0]            quot_ext;
   atab_pkg::atab_tag_type head_tag;

   always_comb begin
      quot_ext     = 28'(c1_num);
      head_tag     = c1_tag;
      head_tag.cyl = quot_ext[15:0];
      head_tag.err = c1_tag.err || (!c1_tag.lba && (|quot_ext[27:16]));
   end

   logic                   c2_valid;
   logic [HRW-1:0]         c2_rem;
   logic [HQW-1:0]         c2_num;
   atab_pkg::atab_tag_type c2_tag;
   logic                   out_hold;

   atab_div_chain #(
      .REM_W (HRW),
      .NUM_W (HQW)
   ) u_head_chain (
      .clock    (clock),
      .reset    (reset),
      .up_valid (c1_valid),
      .up_rem   (c1_rem[CRW-1:HQW]),
      .up_num   (c1_rem[HQW-1:0]),
      .up_tag   (head_tag),
      .divisor  (sectors_ff),
      .up_hold  (c2_hold),
      .dn_valid (c2_valid),
      .dn_rem   (c2_rem),
      .dn_num   (c2_num),
      .dn_tag   (c2_tag),
      .dn_hold  (out_hold)
   );

   // Result assembly and output register.
   atab_pkg::atab_rsp_type rsp_in;
   atab_pkg::atab_rsp_type rsp_ff;
   logic                   rsp_valid_ff;
   logic [7:0]             slave_bit;

   always_comb begin
      slave_bit = slave_ff ? atab_pkg::DH_SLAVE : 8'h00;
      rsp_in    = '0;
      priority if (c2_tag.err) begin
         rsp_in.range_error = 1'b1;
      end else if (c2_tag.lba) begin
         rsp_in.sector_byte        = c2_tag.block[7:0];
         rsp_in.cylinder_low_byte  = c2_tag.block[15:8];
         rsp_in.cylinder_high_byte = c2_tag.block[23:16];
         rsp_in.drive_head_byte    = atab_pkg::DH_BASE | slave_bit | atab_pkg::DH_LBA |
                                     {4'h0, c2_tag.block[27:24]};
         rsp_in.command_byte       = c2_tag.wr ? atab_pkg::CMD_WRITE : atab_pkg::CMD_READ;
      end else begin
         rsp_in.sector_byte        = 8'(c2_rem) + 8'd1;
         rsp_in.cylinder_low_byte  = c2_tag.cyl[7:0];
         rsp_in.cylinder_high_byte = c2_tag.cyl[15:8];
         rsp_in.drive_head_byte    = atab_pkg::DH_BASE | slave_bit | {4'h0, c2_num};
         rsp_in.command_byte       = c2_tag.wr ? atab_pkg::CMD_WRITE : atab_pkg::CMD_READ;
      end
   end

   assign out_hold = rsp_valid_ff & rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!out_hold) begin
         rsp_valid_ff <= c2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_hold) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A finished request in the last cell moves into a free output register.
   a_last_cell_drains: assert property (@(posedge clock) disable iff (reset)
      (c2_valid && !out_hold) |=> rsp_valid_ff)
      else $error("finished request did not reach the output register");

   // A good result always carries a read or a write command.
   a_command_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.range_error) |->
      (rsp_ff.command_byte == atab_pkg::CMD_READ ||
       rsp_ff.command_byte == atab_pkg::CMD_WRITE))
      else $error("good result without a valid command code");

   // Sector numbers are one-based in cylinder/head/sector mode.
   a_chs_sector_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.range_error && !rsp_ff.drive_head_byte[6]) |->
      (rsp_ff.sector_byte != 8'd0))
      else $error("zero sector number in CHS result");

   // Nothing is offered on the response side right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("response valid right after reset");

endmodule
